@@ rtl/qsort_pkg.sv @@
package qsort_pkg;

  localparam int MaxElems     = 64;
  localparam int KeyWidth     = 32;
  localparam int SmallSegment = 7;
  localparam int StackDepth   = 8;
  localparam int IdxW         = $clog2(MaxElems);
  localparam int CntW         = $clog2(MaxElems + 1);
  localparam int SpW          = $clog2(StackDepth + 1);
  localparam int StkIdxW      = $clog2(StackDepth);

  localparam logic [1:0] RegSignedCompare = 2'd0;

  typedef struct packed {
    logic [31:0] key_value;
    logic        last_item;
  } qs_in_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        run_end;
  } qs_out_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_POP,
    S_POPRD,
    S_INS_I,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_M1_RD,
    S_M1_CMP,
    S_M2_RD,
    S_M2_CMP,
    S_M3_RD,
    S_M3_CMP,
    S_PV_RD,
    S_PI_RD,
    S_PI_CMP,
    S_PK_RD,
    S_PK_CMP,
    S_PSWAP,
    S_PEND_RD,
    S_PEND_WR,
    S_PUSH1,
    S_PUSH2,
    S_SW_WR,
    S_EMIT_RD,
    S_EMIT
  } qs_state_t;

endpackage

@@ rtl/quicksort_engine.sv @@
// quicksort_engine: batch key sorter.
// Input channel in_*: one key per transfer. A transfer with last_item set,
// or the one that fills the 64-entry store, closes the batch.
// While loading, in_stall is low, so keys can arrive back to back. After
// close the block sorts in place with a single key comparator and a
// single-port store (one read or write per cycle): quicksort,
// median-of-three pivot, explicit 8-entry segment stack, insertion sort
// for segments under 7 keys and for segments that find the stack full.
// Results leave on out_* in ascending order, the final one with run_end.
// Each result is read from the store, then loaded into the output register.
// in_stall is high from batch close until the last result is in the output
// register; the next batch may load while that result waits.
// out_stall simply holds the output register; nothing is lost.
// Reset (rst_n low, synchronous) empties the batch and clears signed_compare.
// cfg port: APB style; register 0 bit 0 = signed_compare, read back too.
module quicksort_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qsort_pkg::qs_in_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qsort_pkg::qs_out_t    out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [1:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import qsort_pkg::*;

  logic [KeyWidth-1:0] mem [MaxElems];
  logic [IdxW-1:0] seg_lo_m [StackDepth];
  logic [CntW-1:0] seg_n_m  [StackDepth];

  qs_state_t st_r, st_nxt, ret_r, ret_nxt;
  logic sgn_r;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic [SpW-1:0]  sp_r, sp_nxt;
  logic [IdxW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IdxW-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  logic [KeyWidth-1:0] a_r, a_nxt, b_r, b_nxt, pv_r, pv_nxt, rd_r;
  logic [IdxW-1:0] ia_r, ia_nxt;
  logic [CntW-1:0] e_r, e_nxt;
  logic out_v_r, out_v_nxt;
  qs_out_t out_r, out_nxt;

  // memory port controls
  logic            m_we;
  logic [IdxW-1:0] m_addr;
  logic [KeyWidth-1:0] m_wd;
  logic            s_we;
  logic [StkIdxW-1:0] s_addr;
  logic [IdxW-1:0] s_lo_wd;
  logic [CntW-1:0] s_n_wd;
  logic [IdxW-1:0] s_lo_rd;
  logic [CntW-1:0] s_n_rd;
  // pending second push
  logic [IdxW-1:0] p2lo_r, p2lo_nxt;
  logic [CntW-1:0] p2n_r, p2n_nxt;
  logic ins_ret_r, ins_ret_nxt;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegSignedCompare) ? {31'd0, sgn_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) sgn_r <= 1'b0;
    else if (cfg_wr && cfg_paddr == RegSignedCompare) sgn_r <= cfg_pwdata[0];
  end

  // the shared comparator: x < y
  function automatic logic kless(input logic [KeyWidth-1:0] x, y, input logic s);
    logic [KeyWidth-1:0] f;
    f = {s, {(KeyWidth-1){1'b0}}};
    return (x ^ f) < (y ^ f);
  endfunction

  // operand select per state, one compare per cycle
  logic [KeyWidth-1:0] cmp_x, cmp_y;
  logic cmp_lt;
  always_comb begin
    case (st_r)
      S_M3_CMP: begin cmp_x = rd_r; cmp_y = a_r; end
      S_PV_RD: begin cmp_x = a_r; cmp_y = b_r; end
      S_PI_CMP, S_PK_CMP: begin cmp_x = pv_r; cmp_y = rd_r; end
      default: begin cmp_x = a_r; cmp_y = rd_r; end
    endcase
  end
  assign cmp_lt = kless(cmp_x, cmp_y, sgn_r);

  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    rd_r <= mem[m_addr];
    if (s_we) begin
      seg_lo_m[s_addr] <= s_lo_wd;
      seg_n_m[s_addr]  <= s_n_wd;
    end
    s_lo_rd <= seg_lo_m[s_addr];
    s_n_rd  <= seg_n_m[s_addr];
  end

  assign in_stall  = (st_r != S_LOAD);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  logic [CntW-1:0] n1, n2, kc, loc, hic;
  always_comb begin
    kc  = CntW'(k_r);
    loc = CntW'(lo_r);
    hic = CntW'(hi_r);
    n1  = kc - loc;
    n2  = hic - kc;
  end

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; fill_nxt = fill_r; sp_nxt = sp_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r; i_nxt = i_r; k_nxt = k_r;
    j_nxt = j_r; n_nxt = n_r; a_nxt = a_r; b_nxt = b_r; pv_nxt = pv_r;
    ia_nxt = ia_r; e_nxt = e_r; p2lo_nxt = p2lo_r; p2n_nxt = p2n_r;
    ins_ret_nxt = ins_ret_r;
    out_v_nxt = out_v_r && out_stall; out_nxt = out_r;
    m_we = 1'b0; m_addr = ia_r; m_wd = a_r;
    s_we = 1'b0; s_addr = StkIdxW'(sp_r); s_lo_wd = lo_r; s_n_wd = n_r;
    case (st_r)
      S_LOAD: begin
        m_addr = IdxW'(fill_r);
        m_wd   = in_data.key_value;
        if (in_acc) begin
          m_we = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (in_data.last_item || fill_r == CntW'(MaxElems - 1)) begin
            lo_nxt = '0; n_nxt = fill_r + 1'b1; sp_nxt = '0; ins_ret_nxt = 1'b0;
            // whole batch as first segment (stack always has room)
            st_nxt = (fill_r == '0) ? S_EMIT_RD : S_POPRD;
            ret_nxt = S_POP;
            e_nxt = '0;
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          st_nxt = S_EMIT_RD; e_nxt = '0;
        end else begin
          sp_nxt = sp_r - 1'b1;
          s_addr = StkIdxW'(sp_r - 1'b1);
          st_nxt = S_INS_I; ret_nxt = S_POPRD;
          ins_ret_nxt = 1'b1;
        end
      end
      S_POPRD: begin
        // segment (lo_r,n_r) ready, or read from stack
        if (ins_ret_r) begin lo_nxt = s_lo_rd; n_nxt = s_n_rd; end
        ins_ret_nxt = 1'b0;
        st_nxt = S_M1_RD;
        hi_nxt = IdxW'((ins_ret_r ? CntW'(s_lo_rd) + s_n_rd : CntW'(lo_r) + n_r) - 1'b1);
        mid_nxt = IdxW'((ins_ret_r ? CntW'(s_lo_rd) : CntW'(lo_r))
                        + ((ins_ret_r ? s_n_rd : n_r) >> 1));
        if ((ins_ret_r ? s_n_rd : n_r) < CntW'(SmallSegment) ||
            (ins_ret_r ? s_n_rd : n_r) < CntW'(3)) begin
          j_nxt = (ins_ret_r ? s_lo_rd : lo_r) + 1'b1;
          st_nxt = S_INS_I; ret_nxt = S_POP;
        end
      end
      S_INS_I: begin
        // S_POP detour only loads stack regs
        if (ret_r == S_POPRD) begin
          st_nxt = S_POPRD;
        end else if (CntW'(j_r) >= CntW'(lo_r) + n_r || j_r == '0) begin
          st_nxt = ret_r;
        end else begin
          k_nxt = j_r; ia_nxt = j_r; st_nxt = S_INS_RD; m_addr = j_r;
        end
      end
      S_INS_RD: begin
        // key being inserted is read only on the first step
        if (k_r == j_r) a_nxt = rd_r;
        m_addr = k_r - 1'b1; st_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        b_nxt = rd_r;
        if (cmp_lt) begin
          m_we = 1'b1; m_addr = k_r; m_wd = rd_r;
          k_nxt = k_r - 1'b1;
          if (k_r - 1'b1 == lo_r) st_nxt = S_INS_WR;
          else begin st_nxt = S_INS_RD; m_we = 1'b1; end
        end else st_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        m_we = 1'b1; m_addr = k_r; m_wd = a_r;
        j_nxt = j_r + 1'b1; st_nxt = S_INS_I;
      end
      S_M1_RD: begin m_addr = mid_r; st_nxt = S_M1_CMP; end
      S_M1_CMP: begin a_nxt = rd_r; m_addr = lo_r; st_nxt = S_M2_RD; end
      S_M2_RD: begin
        b_nxt = rd_r;
        if (cmp_lt) begin
          m_we = 1'b1; m_addr = lo_r; m_wd = a_r; b_nxt = a_r; a_nxt = rd_r;
        end
        st_nxt = S_M2_CMP;
      end
      S_M2_CMP: begin
        m_we = 1'b1; m_addr = mid_r; m_wd = a_r; st_nxt = S_M3_RD;
      end
      S_M3_RD: begin m_addr = hi_r; st_nxt = S_M3_CMP; pv_nxt = b_r; end
      S_M3_CMP: begin
        // a=mid, pv=lo; rd=hi
        if (cmp_lt) begin
          // hi below mid: old mid goes to hi, lo/hi order settled next cycle
          m_we = 1'b1; m_addr = hi_r; m_wd = a_r;
          a_nxt = rd_r; b_nxt = pv_r; i_nxt = '0;
          st_nxt = S_PV_RD;
        end else begin
          b_nxt = pv_r; st_nxt = S_PSWAP; ret_nxt = S_PV_RD; i_nxt = '1;
        end
      end
      S_PV_RD: begin
        if (i_r != '1) begin
          // a=old hi, b=lo: smaller to lo, the other becomes mid
          m_we = 1'b1; m_addr = lo_r; m_wd = cmp_lt ? a_r : b_r;
          if (cmp_lt) begin a_nxt = b_r; b_nxt = a_r; end
          st_nxt = S_PSWAP; i_nxt = '1;
          ret_nxt = S_PV_RD;
        end else begin
          pv_nxt = a_r; i_nxt = lo_r + 1'b1; k_nxt = hi_r - 1'b1; st_nxt = S_PI_RD;
        end
      end
      S_PSWAP: begin
        if (ret_r == S_PV_RD) begin
          m_we = 1'b1; m_addr = mid_r; m_wd = a_r; st_nxt = S_PV_RD;
        end else begin
          // swap i,k : a=elem i, b=elem k
          m_we = 1'b1; m_addr = i_r; m_wd = b_r; st_nxt = S_SW_WR;
        end
      end
      S_SW_WR: begin
        m_we = 1'b1; m_addr = k_r; m_wd = a_r;
        if (mid_r == i_r) mid_nxt = k_r;
        else if (mid_r == k_r) mid_nxt = i_r;
        i_nxt = i_r + 1'b1; k_nxt = k_r - 1'b1; st_nxt = S_PI_RD;
      end
      S_PI_RD: begin
        if (i_r < k_r) begin m_addr = i_r; st_nxt = S_PI_CMP; end
        else st_nxt = S_PK_RD;
      end
      S_PI_CMP: begin
        a_nxt = rd_r;
        if (!cmp_lt) begin i_nxt = i_r + 1'b1; st_nxt = S_PI_RD; end
        else st_nxt = S_PK_RD;
      end
      S_PK_RD: begin
        if (k_r >= i_r && k_r != '1 && !(k_r == '1)) begin
          m_addr = k_r; st_nxt = S_PK_CMP;
        end else st_nxt = S_PEND_RD;
        if (k_r < i_r) st_nxt = S_PEND_RD;
      end
      S_PK_CMP: begin
        b_nxt = rd_r;
        if (cmp_lt) begin
          k_nxt = k_r - 1'b1;
          st_nxt = (k_r == '0) ? S_PEND_RD : S_PK_RD;
        end else if (k_r <= i_r) st_nxt = S_PEND_RD;
        else begin m_addr = i_r; st_nxt = S_PSWAP; ret_nxt = S_PSWAP; end
      end
      S_PEND_RD: begin
        if (k_r != mid_r) begin m_addr = k_r; st_nxt = S_PEND_WR; end
        else st_nxt = S_PUSH1;
      end
      S_PEND_WR: begin
        m_we = 1'b1; m_addr = mid_r; m_wd = rd_r; ia_nxt = k_r;
        st_nxt = S_PUSH1; a_nxt = pv_r;
        j_nxt = '1;
      end
      S_PUSH1: begin
        if (j_r == '1 && st_r == S_PUSH1 && k_r != mid_r && ia_r == k_r) begin
          m_we = 1'b1; m_addr = k_r; m_wd = pv_r; ia_nxt = ~k_r;
        end else begin
          // order pushes: larger first
          if (n2 > n1) begin
            lo_nxt = k_r + 1'b1; n_nxt = n2; p2lo_nxt = lo_r; p2n_nxt = n1;
          end else begin
            lo_nxt = lo_r; n_nxt = n1; p2lo_nxt = k_r + 1'b1; p2n_nxt = n2;
          end
          j_nxt = '0; st_nxt = S_PUSH2; ret_nxt = S_PUSH1;
        end
      end
      S_PUSH2: begin
        // push (lo_r,n_r) if >1 (insertion sort instead if the stack is full), then swap in p2
        if (ret_r == S_PUSH1) begin
          if (n_r > CntW'(1)) begin
            if (sp_r >= SpW'(StackDepth)) begin
              j_nxt = lo_r + 1'b1; st_nxt = S_INS_I; ret_nxt = S_PUSH2;
            end else begin
              s_we = 1'b1; sp_nxt = sp_r + 1'b1; ret_nxt = S_PUSH2;
            end
          end else ret_nxt = S_PUSH2;
          if (!(n_r > CntW'(1) && sp_r >= SpW'(StackDepth))) begin
            lo_nxt = p2lo_r; n_nxt = p2n_r; ret_nxt = S_INS_WR;
          end
        end else if (ret_r == S_PUSH2) begin
          lo_nxt = p2lo_r; n_nxt = p2n_r; ret_nxt = S_INS_WR;
        end else begin
          if (n_r > CntW'(1)) begin
            if (sp_r >= SpW'(StackDepth)) begin
              j_nxt = lo_r + 1'b1; st_nxt = S_INS_I; ret_nxt = S_POP;
            end else begin s_we = 1'b1; sp_nxt = sp_r + 1'b1; st_nxt = S_POP; end
          end else st_nxt = S_POP;
        end
      end
      S_EMIT_RD: begin
        if (!out_v_r || !out_stall) begin m_addr = IdxW'(e_r); st_nxt = S_EMIT; end
      end
      S_EMIT: begin
        out_v_nxt = 1'b1;
        out_nxt.sorted_key = rd_r;
        out_nxt.run_end = (e_r + 1'b1 == fill_r);
        e_nxt = e_r + 1'b1;
        if (e_r + 1'b1 == fill_r) begin st_nxt = S_LOAD; fill_nxt = '0; end
        else st_nxt = S_EMIT_RD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; fill_r <= '0; sp_r <= '0; out_v_r <= 1'b0;
      ret_r <= S_POP; ins_ret_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; sp_r <= sp_nxt; out_v_r <= out_v_nxt;
      ret_r <= ret_nxt; ins_ret_r <= ins_ret_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt; i_r <= i_nxt; k_r <= k_nxt;
    j_r <= j_nxt; n_r <= n_nxt; a_r <= a_nxt; b_r <= b_nxt; pv_r <= pv_nxt;
    ia_r <= ia_nxt; e_r <= e_nxt; p2lo_r <= p2lo_nxt; p2n_r <= p2n_nxt;
    out_r <= out_nxt;
  end

  a_stall_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD) |-> in_stall)
    else $error("input taken while sorting");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SpW'(StackDepth))
    else $error("stack pointer overflow");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(MaxElems))
    else $error("fill count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> (out_v_r && $stable(out_r)))
    else $error("result dropped under stall");
endmodule

@@ sim/quicksort_engine_test.sv @@
`timescale 1ns / 1ps

module quicksort_engine_test;
  import qsort_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  qs_in_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  qs_out_t     out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Generous limit: ~430 keys, each batch with its full sort time plus random
  // gaps on both sides per key.
  localparam int CycleLimit = 2_000_000;
  // Slack after the last result; the block is idle once run_end has left.
  localparam int DrainCycles = 50;

  quicksort_engine dut (.*);

  always #4 clk = ~clk;

  // Predictor state: open batch and the compare mode in effect.
  logic [31:0] batch_keys[$];
  logic        signed_mode;
  qs_out_t     sorted_expect[$];
  qs_in_t      key_queue[$];
  int          errors;
  int          cycles;
  bit          stim_done;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic bit orders_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] flip;
    flip = signed_mode ? 32'h8000_0000 : 32'h0;
    return (a ^ flip) < (b ^ flip);
  endfunction

  // Keys are plain values, so any correct sort yields the same order as the
  // block's quicksort; a stable insertion sort is enough here.
  task automatic close_batch();
    logic [31:0] arr[$];
    logic [31:0] t;
    int k;
    qs_out_t r;
    arr = batch_keys;
    for (int i = 1; i < arr.size(); i++) begin
      t = arr[i];
      k = i;
      while (k > 0 && orders_before(t, arr[k-1])) begin
        arr[k] = arr[k-1];
        k--;
      end
      arr[k] = t;
    end
    foreach (arr[i]) begin
      r.sorted_key = arr[i];
      r.run_end = (i == arr.size() - 1);
      sorted_expect.push_back(r);
    end
    batch_keys.delete();
  endtask

  task automatic load_key(input qs_in_t it);
    batch_keys.push_back(it.key_value);
    if (it.last_item || batch_keys.size() == MaxElems) close_batch();
  endtask

  // Driver: waits a random gap before each transfer.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        load_key(in_data);
        void'(key_queue.pop_front());
        send_gap <= $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
        in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (key_queue.size() > 0) begin
          in_data  <= key_queue[0];
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each result transfer, draws stalls per result.
  int stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sorted_expect.size() == 0) report("result with none expected");
        else begin
          if (out_data.sorted_key !== sorted_expect[0].sorted_key)
            report($sformatf("key %h, want %h", out_data.sorted_key,
                             sorted_expect[0].sorted_key));
          if (out_data.run_end !== sorted_expect[0].run_end)
            report($sformatf("run_end %b, want %b", out_data.run_end,
                             sorted_expect[0].run_end));
          void'(sorted_expect.pop_front());
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= RegSignedCompare;
    cfg_pwdata <= {31'($urandom_range(0, 32'h7fff_ffff)), m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    signed_mode = m;
    @(posedge clk);
    if (cfg_prdata[0] !== m) report("signed_compare readback");
  endtask

  task automatic wait_idle();
    while (key_queue.size() > 0 || in_valid || sorted_expect.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic queue_key(input logic [31:0] k, input logic lst);
    qs_in_t it;
    it.key_value = k;
    it.last_item = lst;
    key_queue.push_back(it);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Random batch; callers make it mostly short, sometimes long (up to the full store), sometimes duplicate-heavy.
  task automatic queue_batch(input int n, input bit dups);
    for (int i = 0; i < n; i++)
      queue_key(dups ? 32'(($urandom_range(0, 3)) << 30) : pick_key(), i == n - 1);
  endtask

  int sent;
  initial begin
    errors = 0;
    signed_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single key, extremes in both modes, ignored register index.
    queue_key(32'h0000_0000, 1'b1);
    queue_key(32'hFFFF_FFFF, 1'b0); queue_key(32'h0000_0000, 1'b0);
    queue_key(32'h8000_0000, 1'b0); queue_key(32'h7FFF_FFFF, 1'b1);
    for (int i = 0; i < 9; i++) queue_key(32'(9 - i), i == 8); // descending
    wait_idle();
    write_mode(1'b1);
    queue_key(32'hFFFF_FFFF, 1'b0); queue_key(32'h0000_0000, 1'b0);
    queue_key(32'h8000_0000, 1'b0); queue_key(32'h7FFF_FFFF, 1'b0);
    queue_key(32'h5555_5555, 1'b0); queue_key(32'hAAAA_AAAA, 1'b1);
    wait_idle();
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 2'd1; cfg_pwdata <= 32'h0;
    @(posedge clk); cfg_penable <= 1'b1;
    @(posedge clk); cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;

    // Store-full closes the batch with last_item low.
    sent = 20;
    for (int i = 0; i < MaxElems; i++) queue_key($urandom, 1'b0);
    sent += MaxElems;
    wait_idle();
    write_mode(1'b0);

    while (sent < 430) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MaxElems)
                                      : $urandom_range(1, 16);
      queue_batch(n, $urandom_range(0, 4) == 0);
      sent += n;
      // Sometimes the sender holds off until all results are back, then may switch mode.
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_mode($urandom_range(0, 1));
      end
    end
    wait_idle();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
